### hw/rtl/ppdr_pkg.sv
// Shared types, widths and constants for the polygon point distance range unit.
// No dependencies; used by the interfaces, the controller, the datapath and the checker.
package ppdr_pkg;

  localparam int COORD_BITS = 21;
  localparam int DIFF_BITS  = 22;
  localparam int DIST_BITS  = 44;
  localparam int AREA_BITS  = 54;
  localparam int OPND_BITS  = 24;
  localparam int PROD_BITS  = 48;
  localparam int SUM_BITS   = 49;
  localparam int WIDE_BITS  = 108;
  localparam int CHUNK_BITS = 22;
  localparam int CNT_BITS   = 6;
  localparam int CFG_IDX_BITS = 1;

  localparam int MUL_OPS   = 12;
  localparam int SQ_OPS    = 3;
  localparam int PI_OPS    = 6;
  localparam int DIV_STEPS = 44;

  // floor(pi * 2^60)
  localparam logic [62:0] PI_Q60 = 63'h3243F6A8885A308D;
  localparam logic [WIDE_BITS-1:0] ROUND_HALF = WIDE_BITS'(1) << 51;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 1'b1;

  // Multiplier operations; the second of each pair completes the sum (the difference for CR).
  typedef enum logic [4:0] {
    OP_NOP, OP_AC0, OP_AC1, OP_BC0, OP_BC1, OP_LN0, OP_LN1,
    OP_D10, OP_D11, OP_D20, OP_D21, OP_CR0, OP_CR1,
    OP_SHH, OP_SHL, OP_SLL,
    OP_PI0, OP_PI1, OP_PI2, OP_PI3, OP_PI4, OP_PI5
  } op_t;

  typedef enum logic [1:0] {MIN_NONE, MIN_ACD, MIN_BCD, MIN_QUO} min_sel_t;

  typedef struct packed {
    op_t      op;
    logic     load_in;
    logic     setup;
    logic     b_first;
    logic     upd_max;
    min_sel_t min_sel;
    logic     div_init;
    logic     div_step;
    logic     diff_load;
    logic     emit;
    logic     save_prev;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic clamp_a;
    logic clamp_b;
  } status_t;

  function automatic op_t mul_op(input logic [3:0] idx);
    case (idx)
      4'd0:    return OP_AC0;
      4'd1:    return OP_AC1;
      4'd2:    return OP_BC0;
      4'd3:    return OP_BC1;
      4'd4:    return OP_LN0;
      4'd5:    return OP_LN1;
      4'd6:    return OP_D10;
      4'd7:    return OP_D11;
      4'd8:    return OP_D20;
      4'd9:    return OP_D21;
      4'd10:   return OP_CR0;
      4'd11:   return OP_CR1;
      default: return OP_NOP;
    endcase
  endfunction

  function automatic op_t sq_op(input logic [1:0] idx);
    case (idx)
      2'd0:    return OP_SHH;
      2'd1:    return OP_SHL;
      2'd2:    return OP_SLL;
      default: return OP_NOP;
    endcase
  endfunction

  function automatic op_t pi_op(input logic [2:0] idx);
    case (idx)
      3'd0:    return OP_PI0;
      3'd1:    return OP_PI1;
      3'd2:    return OP_PI2;
      3'd3:    return OP_PI3;
      3'd4:    return OP_PI4;
      3'd5:    return OP_PI5;
      default: return OP_NOP;
    endcase
  endfunction

endpackage

### hw/rtl/ppdr_vertex_if.sv
// Vertex input channel: valid/ready handshake with one vertex word.
// Depends on ppdr_pkg for field widths.
interface ppdr_vertex_if;
  logic valid;
  logic ready;
  logic signed [ppdr_pkg::COORD_BITS-1:0] vertex_x;
  logic signed [ppdr_pkg::COORD_BITS-1:0] vertex_y;
  logic last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

### hw/rtl/ppdr_result_if.sv
// Result output channel: valid/ready handshake with one distance range word.
// Depends on ppdr_pkg for field widths.
interface ppdr_result_if;
  logic valid;
  logic ready;
  logic [ppdr_pkg::DIST_BITS-1:0] min_dist_sq;
  logic [ppdr_pkg::DIST_BITS-1:0] max_dist_sq;
  logic [ppdr_pkg::AREA_BITS-1:0] ring_area_q8;

  modport source (output valid, output min_dist_sq, output max_dist_sq,
                  output ring_area_q8, input ready);
  modport sink (input valid, input min_dist_sq, input max_dist_sq,
                input ring_area_q8, output ready);
endinterface

### hw/rtl/ppdr_dpath.sv
// Datapath: shared 24x24 multiplier, accumulators, bit-serial divider, vertex state.
// Depends on ppdr_pkg; driven by ppdr_ctrl through cmd_t.
module ppdr_dpath (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ppdr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ppdr_pkg::COORD_BITS-1:0] cfg_data,
  input  logic signed [ppdr_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [ppdr_pkg::COORD_BITS-1:0] vertex_y,
  input  logic last_vertex,
  input  ppdr_pkg::cmd_t cmd,
  output ppdr_pkg::status_t status,
  output logic [ppdr_pkg::DIST_BITS-1:0] min_dist_sq,
  output logic [ppdr_pkg::DIST_BITS-1:0] max_dist_sq,
  output logic [ppdr_pkg::AREA_BITS-1:0] ring_area_q8
);

  logic signed [ppdr_pkg::COORD_BITS-1:0] center_x, center_y;
  logic signed [ppdr_pkg::COORD_BITS-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic signed [ppdr_pkg::COORD_BITS-1:0] bx, by;
  logic last, have_prev;
  logic [ppdr_pkg::DIST_BITS-1:0] min_acc, max_acc;
  logic signed [ppdr_pkg::DIFF_BITS-1:0] abx, aby, acx, acy, bcx, bcy;
  logic signed [ppdr_pkg::OPND_BITS-1:0] opa, opb;
  logic signed [ppdr_pkg::PROD_BITS-1:0] prod, acc;
  ppdr_pkg::op_t op_q;
  logic signed [ppdr_pkg::SUM_BITS-1:0] sum, dif, dif_neg;
  logic [ppdr_pkg::DIST_BITS-1:0] acd, bcd, len, cabs, diff, rem, dsel;
  logic clamp_a, clamp_b;
  logic [ppdr_pkg::WIDE_BITS-1:0] wide, prod_w;
  logic [ppdr_pkg::DIST_BITS:0] trial, trial_sub;
  logic trial_ge;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppdr_pkg::REG_CENTER_X: center_x <= cfg_data;
        ppdr_pkg::REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // current vertex word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x <= vertex_x;
      cur_y <= vertex_y;
      last  <= last_vertex;
    end
  end

  // polygon state; cleared by reset and after each result
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      first_x   <= '0;
      first_y   <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      min_acc   <= '1;
      max_acc   <= '0;
    end else begin
      if (cmd.load_in && !have_prev) begin
        first_x <= vertex_x;
        first_y <= vertex_y;
      end
      if (cmd.save_prev) begin
        prev_x    <= cur_x;
        prev_y    <= cur_y;
        have_prev <= 1'b1;
      end
      if (cmd.upd_max && (acd > max_acc)) max_acc <= acd;
      if ((cmd.min_sel != ppdr_pkg::MIN_NONE) && (dsel < min_acc)) min_acc <= dsel;
    end
  end

  always_comb begin
    case (cmd.min_sel)
      ppdr_pkg::MIN_ACD: dsel = acd;
      ppdr_pkg::MIN_BCD: dsel = bcd;
      ppdr_pkg::MIN_QUO: dsel = wide[ppdr_pkg::DIST_BITS-1:0];
      default:           dsel = '1;
    endcase
  end

  // edge vectors: A is the current vertex, B the previous or first one
  assign bx = cmd.b_first ? first_x : prev_x;
  assign by = cmd.b_first ? first_y : prev_y;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      abx <= ppdr_pkg::DIFF_BITS'(bx) - ppdr_pkg::DIFF_BITS'(cur_x);
      aby <= ppdr_pkg::DIFF_BITS'(by) - ppdr_pkg::DIFF_BITS'(cur_y);
      acx <= ppdr_pkg::DIFF_BITS'(center_x) - ppdr_pkg::DIFF_BITS'(cur_x);
      acy <= ppdr_pkg::DIFF_BITS'(center_y) - ppdr_pkg::DIFF_BITS'(cur_y);
      bcx <= ppdr_pkg::DIFF_BITS'(center_x) - ppdr_pkg::DIFF_BITS'(bx);
      bcy <= ppdr_pkg::DIFF_BITS'(center_y) - ppdr_pkg::DIFF_BITS'(by);
    end
    if (cmd.diff_load) diff <= (max_acc >= min_acc) ? (max_acc - min_acc) : '0;
  end

  // operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      ppdr_pkg::OP_AC0: begin opa = ppdr_pkg::OPND_BITS'(acx); opb = ppdr_pkg::OPND_BITS'(acx); end
      ppdr_pkg::OP_AC1: begin opa = ppdr_pkg::OPND_BITS'(acy); opb = ppdr_pkg::OPND_BITS'(acy); end
      ppdr_pkg::OP_BC0: begin opa = ppdr_pkg::OPND_BITS'(bcx); opb = ppdr_pkg::OPND_BITS'(bcx); end
      ppdr_pkg::OP_BC1: begin opa = ppdr_pkg::OPND_BITS'(bcy); opb = ppdr_pkg::OPND_BITS'(bcy); end
      ppdr_pkg::OP_LN0: begin opa = ppdr_pkg::OPND_BITS'(abx); opb = ppdr_pkg::OPND_BITS'(abx); end
      ppdr_pkg::OP_LN1: begin opa = ppdr_pkg::OPND_BITS'(aby); opb = ppdr_pkg::OPND_BITS'(aby); end
      ppdr_pkg::OP_D10: begin opa = ppdr_pkg::OPND_BITS'(abx); opb = ppdr_pkg::OPND_BITS'(acx); end
      ppdr_pkg::OP_D11: begin opa = ppdr_pkg::OPND_BITS'(aby); opb = ppdr_pkg::OPND_BITS'(acy); end
      ppdr_pkg::OP_D20: begin opa = ppdr_pkg::OPND_BITS'(abx); opb = ppdr_pkg::OPND_BITS'(bcx); end
      ppdr_pkg::OP_D21: begin opa = ppdr_pkg::OPND_BITS'(aby); opb = ppdr_pkg::OPND_BITS'(bcy); end
      ppdr_pkg::OP_CR0: begin opa = ppdr_pkg::OPND_BITS'(abx); opb = ppdr_pkg::OPND_BITS'(acy); end
      ppdr_pkg::OP_CR1: begin opa = ppdr_pkg::OPND_BITS'(aby); opb = ppdr_pkg::OPND_BITS'(acx); end
      ppdr_pkg::OP_SHH: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(cabs[43:22]));
        opb = signed'(ppdr_pkg::OPND_BITS'(cabs[43:22]));
      end
      ppdr_pkg::OP_SHL: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(cabs[43:22]));
        opb = signed'(ppdr_pkg::OPND_BITS'(cabs[21:0]));
      end
      ppdr_pkg::OP_SLL: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(cabs[21:0]));
        opb = signed'(ppdr_pkg::OPND_BITS'(cabs[21:0]));
      end
      ppdr_pkg::OP_PI0: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[21:0]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[20:0]));
      end
      ppdr_pkg::OP_PI1: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[21:0]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[41:21]));
      end
      ppdr_pkg::OP_PI2: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[21:0]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[62:42]));
      end
      ppdr_pkg::OP_PI3: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[43:22]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[20:0]));
      end
      ppdr_pkg::OP_PI4: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[43:22]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[41:21]));
      end
      ppdr_pkg::OP_PI5: begin
        opa = signed'(ppdr_pkg::OPND_BITS'(diff[43:22]));
        opb = signed'(ppdr_pkg::OPND_BITS'(ppdr_pkg::PI_Q60[62:42]));
      end
      default: ;
    endcase
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    if (rst) op_q <= ppdr_pkg::OP_NOP;
    else     op_q <= cmd.op;
    prod <= opa * opb;
  end

  assign sum     = ppdr_pkg::SUM_BITS'(acc) + ppdr_pkg::SUM_BITS'(prod);
  assign dif     = ppdr_pkg::SUM_BITS'(acc) - ppdr_pkg::SUM_BITS'(prod);
  assign dif_neg = -dif;
  assign prod_w  = ppdr_pkg::WIDE_BITS'(unsigned'(prod));

  // restoring divide step: remainder and dividend/quotient shift in wide[43:0]
  assign trial     = {rem, wide[ppdr_pkg::DIST_BITS-1]};
  assign trial_sub = trial - {1'b0, len};
  assign trial_ge  = !trial_sub[ppdr_pkg::DIST_BITS];

  // accumulate stage
  always_ff @(posedge clk) begin
    if (cmd.div_init) rem <= wide[87:44];
    if (cmd.div_step) begin
      rem <= trial_ge ? trial_sub[ppdr_pkg::DIST_BITS-1:0] : trial[ppdr_pkg::DIST_BITS-1:0];
      wide[ppdr_pkg::DIST_BITS-1:0] <= {wide[ppdr_pkg::DIST_BITS-2:0], trial_ge};
    end else begin
      case (op_q)
        ppdr_pkg::OP_AC0, ppdr_pkg::OP_BC0, ppdr_pkg::OP_LN0,
        ppdr_pkg::OP_D10, ppdr_pkg::OP_D20, ppdr_pkg::OP_CR0: acc <= prod;
        ppdr_pkg::OP_AC1: acd <= sum[ppdr_pkg::DIST_BITS-1:0];
        ppdr_pkg::OP_BC1: bcd <= sum[ppdr_pkg::DIST_BITS-1:0];
        ppdr_pkg::OP_LN1: len <= sum[ppdr_pkg::DIST_BITS-1:0];
        ppdr_pkg::OP_D11: clamp_a <= sum[ppdr_pkg::SUM_BITS-1] || (sum == '0);
        ppdr_pkg::OP_D21: clamp_b <= !sum[ppdr_pkg::SUM_BITS-1];
        ppdr_pkg::OP_CR1: cabs <= dif[ppdr_pkg::SUM_BITS-1] ? dif_neg[ppdr_pkg::DIST_BITS-1:0]
                                                            : dif[ppdr_pkg::DIST_BITS-1:0];
        ppdr_pkg::OP_SHH: wide <= prod_w << 44;
        ppdr_pkg::OP_SHL: wide <= wide + (prod_w << 23);
        ppdr_pkg::OP_SLL: wide <= wide + prod_w;
        ppdr_pkg::OP_PI0: wide <= ppdr_pkg::ROUND_HALF + prod_w;
        ppdr_pkg::OP_PI1: wide <= wide + (prod_w << 21);
        ppdr_pkg::OP_PI2: wide <= wide + (prod_w << 42);
        ppdr_pkg::OP_PI3: wide <= wide + (prod_w << 22);
        ppdr_pkg::OP_PI4: wide <= wide + (prod_w << 43);
        ppdr_pkg::OP_PI5: wide <= wide + (prod_w << 64);
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      min_dist_sq  <= min_acc;
      max_dist_sq  <= max_acc;
      ring_area_q8 <= wide[105:52];
    end
  end

  assign status.have_prev = have_prev;
  assign status.last      = last;
  assign status.clamp_a   = clamp_a;
  assign status.clamp_b   = clamp_b;

endmodule

### hw/rtl/ppdr_ctrl.sv
// Controller: sequences multiplier ops, divide steps and result emission per vertex.
// Depends on ppdr_pkg; drives ppdr_dpath through cmd_t.
module ppdr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic vtx_valid,
  output logic vtx_ready,
  output logic res_valid,
  input  logic res_ready,
  input  ppdr_pkg::status_t status,
  output ppdr_pkg::cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SETUP  = 14'b00000000000010,
    S_MUL    = 14'b00000000000100,
    S_DRAIN  = 14'b00000000001000,
    S_CHECK  = 14'b00000000010000,
    S_SQ     = 14'b00000000100000,
    S_SQWAIT = 14'b00000001000000,
    S_DINIT  = 14'b00000010000000,
    S_DIV    = 14'b00000100000000,
    S_QUO    = 14'b00001000000000,
    S_NEXT   = 14'b00010000000000,
    S_DIFF   = 14'b00100000000000,
    S_PI     = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [ppdr_pkg::CNT_BITS-1:0] cnt, cnt_next;
  logic pass2, pass2_next;
  logic out_valid, out_valid_next;
  logic do_min;

  // second pass is the closing edge; first pass tests an edge only if one exists
  assign do_min = pass2 || status.have_prev || status.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pass2     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pass2     <= pass2_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pass2_next     = pass2;
    out_valid_next = out_valid && !res_ready;
    vtx_ready      = 1'b0;
    cmd            = '0;
    cmd.op         = ppdr_pkg::OP_NOP;
    cmd.b_first    = pass2 || !status.have_prev;
    case (state)
      S_IDLE: begin
        vtx_ready = 1'b1;
        if (vtx_valid) begin
          cmd.load_in = 1'b1;
          pass2_next  = 1'b0;
          state_next  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op   = ppdr_pkg::mul_op(cnt[3:0]);
        cnt_next = cnt + 1'b1;
        if (cnt == ppdr_pkg::CNT_BITS'(ppdr_pkg::MUL_OPS - 1)) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_CHECK;
      S_CHECK: begin
        cmd.upd_max = 1'b1;
        cnt_next    = '0;
        if (!do_min) begin
          state_next = S_NEXT;
        end else if (status.clamp_a) begin
          cmd.min_sel = ppdr_pkg::MIN_ACD;
          state_next  = S_NEXT;
        end else if (status.clamp_b) begin
          cmd.min_sel = ppdr_pkg::MIN_BCD;
          state_next  = S_NEXT;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op   = ppdr_pkg::sq_op(cnt[1:0]);
        cnt_next = cnt + 1'b1;
        if (cnt == ppdr_pkg::CNT_BITS'(ppdr_pkg::SQ_OPS - 1)) state_next = S_SQWAIT;
      end
      S_SQWAIT: state_next = S_DINIT;
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == ppdr_pkg::CNT_BITS'(ppdr_pkg::DIV_STEPS - 1)) state_next = S_QUO;
      end
      S_QUO: begin
        cmd.min_sel = ppdr_pkg::MIN_QUO;
        state_next  = S_NEXT;
      end
      S_NEXT: begin
        if (status.last && !pass2 && status.have_prev) begin
          pass2_next = 1'b1;
          state_next = S_SETUP;
        end else if (status.last) begin
          state_next = S_DIFF;
        end else begin
          cmd.save_prev = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DIFF: begin
        cmd.diff_load = 1'b1;
        cnt_next      = '0;
        state_next    = S_PI;
      end
      S_PI: begin
        cmd.op   = ppdr_pkg::pi_op(cnt[2:0]);
        cnt_next = cnt + 1'b1;
        // one extra idle slot so the last product reaches the accumulator
        if (cnt == ppdr_pkg::CNT_BITS'(ppdr_pkg::PI_OPS)) state_next = S_EMIT;
      end
      S_EMIT: begin
        // accumulator is complete here
        if (!out_valid || res_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res_valid = out_valid;

endmodule

### hw/rtl/polygon_point_distance_range_unit.sv
// A vertex with no edge to test, or an edge clamped to an endpoint, skips squaring and divide;
// an edge needing the perpendicular distance adds 3 squaring ops and a 44-step divide.
// A closing vertex with a previous vertex tests its own edge, then the closing edge, then the pi product and emit.
// One vertex at a time: the shared 24x24 multiplier and bit-serial divider finish a vertex
// before the next. Reset (rst, synchronous) clears the center to 0 and all polygon state.
//
// Top level of the polygon point distance range unit.
// Depends on ppdr_pkg, ppdr_vertex_if, ppdr_result_if, ppdr_ctrl and ppdr_dpath.
//
// Vertices arrive one word per handshake on vtx. Each vertex A is paired with the
// previous vertex B (or the first one when closing the polygon) and the edge is
// tested against the center C:
//   - dot products of AB with AC and BC decide whether C projects past an endpoint,
//     in which case the endpoint distance is used;
//   - otherwise |AB x AC|^2 / |AB|^2 is formed: the cross product is squared from
//     three 22-bit partial products into a wide accumulator and divided bit-serially.
// The largest vertex distance and the smallest edge distance accumulate until the
// word marked last_vertex; then the closing edge is tested, pi*(max-min) is formed
// from six partial products with round-half-up into Q8, and the result word is
// loaded into the output register. Polygon state clears at that point.
// The output register parts the two sides: a new polygon may start while the
// result waits; the block only stalls in its emit step if the old word is unread.
module polygon_point_distance_range_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ppdr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ppdr_pkg::COORD_BITS-1:0] cfg_data,
  ppdr_vertex_if.sink vtx,
  ppdr_result_if.source res
);

  ppdr_pkg::cmd_t    cmd;
  ppdr_pkg::status_t status;

  // sequencing: one-hot FSM stepping through the multiplier op lists
  ppdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx.valid),
    .vtx_ready (vtx.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, polygon state and the result register
  ppdr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_x     (vtx.vertex_x),
    .vertex_y     (vtx.vertex_y),
    .last_vertex  (vtx.last_vertex),
    .cmd          (cmd),
    .status       (status),
    .min_dist_sq  (res.min_dist_sq),
    .max_dist_sq  (res.max_dist_sq),
    .ring_area_q8 (res.ring_area_q8)
  );

endmodule

### hw/rtl/ppdr_checker.sv
// Port-level checker for the polygon point distance range unit, bound to the top level.
// Depends on ppdr_pkg for field widths.
module ppdr_checker (
  input logic clk,
  input logic rst,
  input logic vtx_valid,
  input logic vtx_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [ppdr_pkg::DIST_BITS-1:0] res_min,
  input logic [ppdr_pkg::DIST_BITS-1:0] res_max,
  input logic [ppdr_pkg::AREA_BITS-1:0] res_area
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_min) && $stable(res_max) && $stable(res_area))
    else $error("result word changed while stalled");

  a_one_vertex: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_ready |=> !vtx_ready)
    else $error("vertex taken while the previous one is still in work");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_min <= res_max)
    else $error("edge minimum exceeds vertex maximum");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind polygon_point_distance_range_unit ppdr_checker u_ppdr_checker (
  .clk       (clk),
  .rst       (rst),
  .vtx_valid (vtx.valid),
  .vtx_ready (vtx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_min   (res.min_dist_sq),
  .res_max   (res.max_dist_sq),
  .res_area  (res.ring_area_q8)
);

### tb/sv/tb.sv
// Self-checking testbench for polygon_point_distance_range_unit.
// Depends on ppdr_pkg, ppdr_vertex_if, ppdr_result_if and the unit itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = ppdr_pkg::COORD_BITS;
  localparam int DIST_BITS    = ppdr_pkg::DIST_BITS;
  localparam int AREA_BITS    = ppdr_pkg::AREA_BITS;
  localparam int CFG_IDX_BITS = ppdr_pkg::CFG_IDX_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = ppdr_pkg::REG_CENTER_X;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = ppdr_pkg::REG_CENTER_Y;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

  typedef struct {
    logic [DIST_BITS-1:0] min_d;
    logic [DIST_BITS-1:0] max_d;
    logic [AREA_BITS-1:0] area;
  } range_word_t;

  // one row of the directed table; known = 1 when the answer is typed in
  typedef struct {
    int          x;
    int          y;
    bit          last;
    bit          known;
    range_word_t want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_CENTER_X;
  logic [COORD_BITS-1:0] cfg_data = '0;

  ppdr_vertex_if vtx_ch ();
  ppdr_result_if res_ch ();

  polygon_point_distance_range_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .vtx(vtx_ch), .res(res_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // Mirror of the block state: center, first/prev vertex, running min/max.
  longint ctr_x, ctr_y;
  longint first_x, first_y, prev_x, prev_y;
  bit     seen_vertex;
  logic [DIST_BITS-1:0] min_run, max_run;

  range_word_t ranges_due[$];
  int mismatches = 0;
  bit idle_tail = 0;

  function automatic logic [DIST_BITS-1:0] clip_dist(logic [127:0] v);
    return (v > 128'(DIST_MAX)) ? DIST_MAX : v[DIST_BITS-1:0];
  endfunction

  function automatic longint sq_len(longint dx, longint dy);
    return dx * dx + dy * dy;
  endfunction

  // squared distance from the center to segment A-B, quotient floored
  function automatic logic [DIST_BITS-1:0] edge_dist_sq(longint ax, longint ay,
                                                        longint bx, longint by);
    longint abx, aby, acx, acy, bcx, bcy, cr, len;
    logic [127:0] cw;
    abx = bx - ax;    aby = by - ay;
    acx = ctr_x - ax; acy = ctr_y - ay;
    bcx = ctr_x - bx; bcy = ctr_y - by;
    if ((-abx) * acx + (-aby) * acy >= 0) return clip_dist(128'(sq_len(acx, acy)));
    if (abx * bcx + aby * bcy >= 0) return clip_dist(128'(sq_len(bcx, bcy)));
    len = sq_len(abx, aby);
    if (len == 0) return clip_dist(128'(sq_len(acx, acy)));
    cr = abx * acy - aby * acx;
    if (cr < 0) cr = -cr;
    cw = 128'(cr);
    return clip_dist((cw * cw) / 128'(len));
  endfunction

  function automatic void clear_polygon();
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    seen_vertex = 0;
    min_run = DIST_MAX;
    max_run = '0;
  endfunction

  // Fold one accepted vertex into the mirror; queue a word on the closing vertex.
  function automatic void predict_vertex(logic [COORD_BITS-1:0] vx,
                                         logic [COORD_BITS-1:0] vy, bit last);
    longint px, py;
    logic [DIST_BITS-1:0] d;
    logic [127:0] prod;
    logic [DIST_BITS-1:0] diff;
    range_word_t w;
    px = longint'($signed(vx));
    py = longint'($signed(vy));
    d = clip_dist(128'(sq_len(px - ctr_x, py - ctr_y)));
    if (d > max_run) max_run = d;
    if (seen_vertex) begin
      d = edge_dist_sq(px, py, prev_x, prev_y);
      if (d < min_run) min_run = d;
    end else begin
      first_x = px; first_y = py;
    end
    prev_x = px; prev_y = py;
    seen_vertex = 1;
    if (!last) return;
    d = edge_dist_sq(px, py, first_x, first_y);
    if (d < min_run) min_run = d;
    diff = (max_run >= min_run) ? max_run - min_run : '0;
    prod = (128'(diff) * 128'(ppdr_pkg::PI_Q60) + (128'(1) << 51)) >> 52;
    w.min_d = min_run;
    w.max_d = max_run;
    w.area  = (prod > 128'(AREA_MAX)) ? AREA_MAX : prod[AREA_BITS-1:0];
    ranges_due = {ranges_due, w};
    clear_polygon();
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= COORD_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    ctr_x = (idx == REG_CENTER_X) ? longint'($signed(COORD_BITS'(value))) : ctr_x;
    ctr_y = (idx == REG_CENTER_Y) ? longint'($signed(COORD_BITS'(value))) : ctr_y;
  endtask

  int burst_left = 0;

  // Offer one vertex word; bursts of back-to-back words separated by random gaps.
  // Called at a rising edge; returns at the edge where the word is accepted.
  task automatic send_vertex(int x, int y, bit last, bit known, range_word_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        vtx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    vtx_ch.valid <= 1'b1;
    vtx_ch.vertex_x <= COORD_BITS'(x);
    vtx_ch.vertex_y <= COORD_BITS'(y);
    vtx_ch.last_vertex <= last;
    do @(posedge clk); while (!vtx_ch.ready);
    // accepted at this edge; the next word is driven at this same edge
    if (known) begin
      ranges_due = {ranges_due, want};
      clear_polygon();
    end else begin
      predict_vertex(COORD_BITS'(x), COORD_BITS'(y), last);
    end
  endtask

  // Hold the sender until every queued word has come back, then let the tail finish.
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    burst_left = 0;
    wait (ranges_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_coord(longint around);
    if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 2097151)) - 1048576;
    return int'(around) + int'($urandom_range(0, 2000)) - 1000;
  endfunction

  task automatic random_polygons(int words);
    int n, i, x, y;
    range_word_t none;
    none = '{default: '0};
    while (words > 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        x = pick_coord(ctr_x);
        y = pick_coord(ctr_y);
        send_vertex(x, y, i == n - 1, 1'b0, none);
      end
      words -= n;
    end
  endtask

  // ---------------------------------------------------------------- directed table
  // Single-vertex polygons give min = max = the vertex distance and zero area.
  vec_row_t vec_table[] = '{
    '{0, 0, 1, 1, '{44'd0, 44'd0, 54'd0}},
    '{3, 4, 1, 1, '{44'd25, 44'd25, 54'd0}},
    '{-1048576, -1048576, 1, 1, '{44'd2199023255552, 44'd2199023255552, 54'd0}},
    '{1048575, 1048575, 1, 1, '{44'd2199019061250, 44'd2199019061250, 54'd0}},
    // square spanning the full coordinate range
    '{-1048576, -1048576, 0, 0, '{default: '0}},
    '{1048575, -1048576, 0, 0, '{default: '0}},
    '{1048575, 1048575, 0, 0, '{default: '0}},
    '{-1048576, 1048575, 1, 0, '{default: '0}},
    // zero length edges
    '{5, 5, 0, 0, '{default: '0}},
    '{5, 5, 0, 0, '{default: '0}},
    '{5, 5, 1, 0, '{default: '0}},
    // center projects inside an edge: perpendicular distance
    '{-100, 7, 0, 0, '{default: '0}},
    '{100, 7, 0, 0, '{default: '0}},
    '{0, 300, 1, 0, '{default: '0}},
    // center falls past an endpoint
    '{10, 10, 0, 0, '{default: '0}},
    '{20, 30, 1, 0, '{default: '0}},
    // quotient with a fraction to floor
    '{-7, 3, 0, 0, '{default: '0}},
    '{11, 5, 0, 0, '{default: '0}},
    '{2, -9, 1, 0, '{default: '0}}
  };

  // ---------------------------------------------------------------- receiver
  bit hold_req  = 0;    // stimulus asks for one long back-pressure stretch
  bit hold_done = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    range_word_t w;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (ranges_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word min=%0d max=%0d area=%0d",
                                         res_ch.min_dist_sq, res_ch.max_dist_sq,
                                         res_ch.ring_area_q8);
        end else begin
          w = ranges_due.pop_front();
          if (res_ch.min_dist_sq !== w.min_d || res_ch.max_dist_sq !== w.max_d ||
              res_ch.ring_area_q8 !== w.area) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp min=%0d max=%0d area=%0d got min=%0d max=%0d area=%0d",
                       w.min_d, w.max_d, w.area, res_ch.min_dist_sq,
                       res_ch.max_dist_sq, res_ch.ring_area_q8);
          end
        end
      end
      // stall pattern: one long hold, else ready drawn at random on each edge (always high in the idle tail)
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        res_ch.ready <= 1'b0;
      end else if (($urandom_range(0, 255) < 96) || idle_tail) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    int i;
    vtx_ch.valid = 1'b0;
    vtx_ch.vertex_x = '0;
    vtx_ch.vertex_y = '0;
    vtx_ch.last_vertex = 1'b0;
    ctr_x = 0;
    ctr_y = 0;
    clear_polygon();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words with the center at reset value
    foreach (vec_table[i])
      send_vertex(vec_table[i].x, vec_table[i].y, vec_table[i].last,
                  vec_table[i].known, vec_table[i].want);
    drain();

    // center at both corners of the range, then random centers
    write_reg(REG_CENTER_X, -1048576);
    write_reg(REG_CENTER_Y, 1048575);
    random_polygons(80);
    drain();

    write_reg(REG_CENTER_X, 1048575);
    write_reg(REG_CENTER_Y, -1048576);
    hold_req = 1;    // receiver blocks while the sender keeps offering words
    random_polygons(80);
    drain();

    for (i = 0; i < 4; i++) begin
      write_reg(REG_CENTER_X, int'($urandom_range(0, 2097151)) - 1048576);
      write_reg(REG_CENTER_Y, int'($urandom_range(0, 2097151)) - 1048576);
      random_polygons(85);
      drain();
    end

    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 0);
    idle_tail = 1;
    random_polygons(10);
    drain();

    if (mismatches == 0 && ranges_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
